FILE: src/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types and character codes for the ascii integer parser.
// ----------------------------------------------------------------------------
`default_nettype none

package aip_pkg;

   localparam int ACC_W   = 64;
   localparam int PHASE_W = 3;
   localparam int CHAR_W  = 8;
   localparam int DIGIT_W = 4;

   // parse phase codes
   localparam logic [PHASE_W-1:0] PH_DONE     = 3'd0;
   localparam logic [PHASE_W-1:0] PH_LEAD     = 3'd1;
   localparam logic [PHASE_W-1:0] PH_POSTSIGN = 3'd2;
   localparam logic [PHASE_W-1:0] PH_ZERO     = 3'd3;
   localparam logic [PHASE_W-1:0] PH_HEX      = 3'd4;
   localparam logic [PHASE_W-1:0] PH_OCT      = 3'd5;
   localparam logic [PHASE_W-1:0] PH_DEC      = 3'd6;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_SEVEN   = 8'h37;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;

   // offset from the low nibble of a hex letter to its digit value
   localparam logic [DIGIT_W-1:0] LETTER_OFFSET = 4'd9;

   typedef struct packed {
      logic               is_nul;
      logic               is_blank;
      logic               is_plus;
      logic               is_minus;
      logic               is_zero;
      logic               is_x;
      logic               dec_ok;
      logic               nonzero_dec;
      logic               oct_ok;
      logic               hex_ok;
      logic [DIGIT_W-1:0] digit;
   } char_class_type;

endpackage

`default_nettype wire

FILE: src/aip_decode.sv
// ----------------------------------------------------------------------------
// aip_decode
// Classifies one character: blanks, signs, prefix letters and digit value.
// ----------------------------------------------------------------------------
`default_nettype none

module aip_decode (
   input  wire logic [aip_pkg::CHAR_W-1:0] char_code,
   output aip_pkg::char_class_type         cls
);
   import aip_pkg::*;

   logic is_upper_hex;
   logic is_lower_hex;

   always_comb begin
      is_upper_hex    = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F);
      is_lower_hex    = (char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F);
      cls.is_nul      = (char_code == CHAR_NUL);
      cls.is_blank    = (char_code == CHAR_SPACE) || (char_code == CHAR_TAB);
      cls.is_plus     = (char_code == CHAR_PLUS);
      cls.is_minus    = (char_code == CHAR_MINUS);
      cls.is_zero     = (char_code == CHAR_ZERO);
      cls.is_x        = (char_code == CHAR_LOWER_X) || (char_code == CHAR_UPPER_X);
      cls.dec_ok      = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      cls.nonzero_dec = cls.dec_ok && !cls.is_zero;
      cls.oct_ok      = (char_code >= CHAR_ZERO) && (char_code <= CHAR_SEVEN);
      cls.hex_ok      = cls.dec_ok || is_upper_hex || is_lower_hex;
      // letters a-f and A-F share the low nibble 1..6
      if (cls.dec_ok) begin
         cls.digit = char_code[DIGIT_W-1:0];
      end else begin
         cls.digit = char_code[DIGIT_W-1:0] + LETTER_OFFSET;
      end
   end

endmodule

`default_nettype wire

FILE: src/aip_engine.sv
// ----------------------------------------------------------------------------
// aip_engine
// Parse state and one-character step: phase, accumulator and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module aip_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic                          start,
   input  wire aip_pkg::char_class_type       cls,
   output logic                               emit,
   output logic signed [aip_pkg::ACC_W-1:0]   value
);
   import aip_pkg::*;

   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]   acc_in;
   logic               neg_ff;
   logic               neg_in;

   logic [PHASE_W-1:0] cur_phase;
   logic [ACC_W-1:0]   cur_acc;
   logic               cur_neg;
   logic [ACC_W-1:0]   scaled;
   logic [ACC_W-1:0]   digit_ext;
   logic               fire;

   always_comb begin
      // a flagged character restarts the parse
      cur_phase = start ? PH_LEAD : phase_ff;
      cur_acc   = start ? '0 : acc_ff;
      cur_neg   = start ? 1'b0 : neg_ff;
      digit_ext = {{(ACC_W-DIGIT_W){1'b0}}, cls.digit};

      case (cur_phase)
         PH_HEX:  scaled = cur_acc << 4;
         PH_OCT:  scaled = cur_acc << 3;
         default: scaled = (cur_acc << 3) + (cur_acc << 1);
      endcase

      phase_in = cur_phase;
      acc_in   = cur_acc;
      neg_in   = cur_neg;
      fire     = 1'b0;

      case (cur_phase)
         PH_LEAD, PH_POSTSIGN: begin
            if (cls.is_blank) begin
               phase_in = cur_phase;
            end else if ((cur_phase == PH_LEAD) && (cls.is_plus || cls.is_minus)) begin
               neg_in   = cls.is_minus;
               phase_in = PH_POSTSIGN;
            end else if (cls.is_zero) begin
               acc_in   = '0;
               phase_in = PH_ZERO;
            end else if (cls.nonzero_dec) begin
               acc_in   = digit_ext;
               phase_in = PH_DEC;
            end else begin
               acc_in = '0;
               fire   = 1'b1;
            end
         end
         PH_ZERO: begin
            if (cls.is_x) begin
               acc_in   = '0;
               phase_in = PH_HEX;
            end else if (cls.oct_ok) begin
               acc_in   = digit_ext;
               phase_in = PH_OCT;
            end else begin
               fire = 1'b1;
            end
         end
         PH_HEX: begin
            if (cls.hex_ok) begin
               acc_in = scaled + digit_ext;
            end else begin
               fire = 1'b1;
            end
         end
         PH_OCT: begin
            if (cls.oct_ok) begin
               acc_in = scaled + digit_ext;
            end else begin
               fire = 1'b1;
            end
         end
         PH_DEC: begin
            if (cls.dec_ok) begin
               acc_in = scaled + digit_ext;
            end else begin
               fire = 1'b1;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      if (fire) begin
         phase_in = PH_DONE;
      end

      emit = step && fire;
      // value leaving on a terminator is the accumulator before this character
      if (cur_neg) begin
         value = $signed(ACC_W'(0) - acc_in);
      end else begin
         value = $signed(acc_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
      end
   end

`ifndef ASSERT_OFF
   a_emit_ends_parse: assert property (@(posedge clock) disable iff (reset)
      emit |=> (phase_ff == PH_DONE))
      else $error("parse not finished after a result");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(phase_ff) && $stable(acc_ff) && $stable(neg_ff)))
      else $error("parse state moved without a request");

   a_done_is_silent: assert property (@(posedge clock) disable iff (reset)
      (step && !start && (phase_ff == PH_DONE)) |-> !emit)
      else $error("result after the parse had finished");
`endif

endmodule

`default_nettype wire

FILE: src/ascii_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser
// The request that ends the number is held in the input register, and its result
// in the result register. One character per cycle, except while the output stalls.
// An input register and a result register sit either side of the step logic.
// Reset (synchronous) leaves the parser finished, waiting for a string start.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_integer_parser (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [aip_pkg::CHAR_W-1:0]          req_char_code,
   input  wire logic                                req_string_start,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [aip_pkg::ACC_W-1:0]         rsp_parsed_value
);
   import aip_pkg::*;

   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic [CHAR_W-1:0]         in_char_ff;
   logic                      in_start_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [ACC_W-1:0]   rsp_value_ff;

   logic                      out_free;
   logic                      step;
   logic                      accept;
   logic                      emit;
   logic signed [ACC_W-1:0]   value;
   char_class_type            cls;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      rsp_valid_in = out_free ? (step && emit) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff  <= req_char_code;
         in_start_ff <= req_string_start;
      end
      if (step && emit) begin
         rsp_value_ff <= value;
      end
   end

   aip_decode u_decode (
      .char_code (in_char_ff),
      .cls       (cls)
   );

   aip_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .start (in_start_ff),
      .cls   (cls),
      .emit  (emit),
      .value (value)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parsed_value = rsp_value_ff;

endmodule

`default_nettype wire

FILE: sim/ascii_integer_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_parser_tb
// Feeds character streams to the parser with random gaps and back-pressure.
// A scoreboard keeps its own parse state, predicts each emitted value from
// the accepted requests and checks every result against the oldest one held.
// ----------------------------------------------------------------------------
module ascii_integer_parser_tb;
   import aip_pkg::*;

   localparam int RESET_CYCLES = 6;
   localparam int ITEM_COUNT   = 1350;
   localparam int QUIET_FROM   = 1200;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;

   class parse_scoreboard;
      logic [PHASE_W-1:0]      phase;
      logic [ACC_W-1:0]        acc;
      bit                      negative;
      logic signed [ACC_W-1:0] expected_values[$];
      int                      mismatches;

      function new();
         phase      = PH_DONE;
         acc        = '0;
         negative   = 1'b0;
         mismatches = 0;
      endfunction

      function void emit_value();
         expected_values.push_back(negative ? $signed(-acc) : $signed(acc));
         phase = PH_DONE;
      endfunction

      // first character of the number proper
      function void begin_number(logic [CHAR_W-1:0] c);
         if (c == CHAR_ZERO) begin
            acc   = '0;
            phase = PH_ZERO;
         end else if (c > CHAR_ZERO && c <= CHAR_NINE) begin
            acc   = ACC_W'(c) - ACC_W'(CHAR_ZERO);
            phase = PH_DEC;
         end else begin
            acc = '0;
            emit_value();
         end
      endfunction

      // returns 1 when the request was not merely ignored
      function bit note_request(logic [CHAR_W-1:0] c, logic start);
         logic [ACC_W-1:0] code;
         bit               acted;
         code  = ACC_W'(c);
         acted = start || (phase != PH_DONE);
         if (start) begin
            phase    = PH_LEAD;
            acc      = '0;
            negative = 1'b0;
         end
         case (phase)
            PH_LEAD: begin
               if (c == CHAR_SPACE || c == CHAR_TAB) begin
               end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
                  negative = (c == CHAR_MINUS);
                  phase    = PH_POSTSIGN;
               end else begin
                  begin_number(c);
               end
            end
            PH_POSTSIGN: begin
               if (c != CHAR_SPACE && c != CHAR_TAB) begin_number(c);
            end
            PH_ZERO: begin
               if (c == CHAR_NUL) begin
                  emit_value();
               end else if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) begin
                  acc   = '0;
                  phase = PH_HEX;
               end else if (c >= CHAR_ZERO && c <= CHAR_SEVEN) begin
                  acc   = code - ACC_W'(CHAR_ZERO);
                  phase = PH_OCT;
               end else begin
                  emit_value();
               end
            end
            PH_HEX: begin
               if (c >= CHAR_ZERO && c <= CHAR_NINE)
                  acc = acc * 16 + (code - ACC_W'(CHAR_ZERO));
               else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
                  acc = acc * 16 + (code - ACC_W'(CHAR_LOWER_A) + 10);
               else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
                  acc = acc * 16 + (code - ACC_W'(CHAR_UPPER_A) + 10);
               else
                  emit_value();
            end
            PH_OCT: begin
               if (c >= CHAR_ZERO && c <= CHAR_SEVEN)
                  acc = acc * 8 + (code - ACC_W'(CHAR_ZERO));
               else
                  emit_value();
            end
            PH_DEC: begin
               if (c >= CHAR_ZERO && c <= CHAR_NINE)
                  acc = acc * 10 + (code - ACC_W'(CHAR_ZERO));
               else
                  emit_value();
            end
            default: phase = PH_DONE;
         endcase
         return acted;
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(logic signed [ACC_W-1:0] got);
         logic signed [ACC_W-1:0] want;
         if (expected_values.size() == 0) begin
            report_mismatch($sformatf("value %0d with none pending", got));
         end else begin
            want = expected_values.pop_front();
            if (got !== want)
               report_mismatch($sformatf("parsed_value %0d (%h), wanted %0d (%h)",
                                         got, got, want, want));
         end
      endtask

      function int pending();
         return expected_values.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic [CHAR_W-1:0]        req_char_code    = '0;
   logic                     req_string_start = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic signed [ACC_W-1:0]  rsp_parsed_value;

   parse_scoreboard sb = new();
   bit              idling_on    = 1'b1;
   int              req_idle_pct = 20;
   int              rsp_stall_pct = 20;
   int              active_items = 0;
   int              cycle_count  = 0;

   ascii_integer_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_string_start (req_string_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parsed_value (rsp_parsed_value)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_parsed_value);
   end

   // result side back-pressure, with quiet stretches
   initial begin
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         if ($urandom_range(0, 63) == 0)
            rsp_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      end
   end

   task automatic send_char(logic [CHAR_W-1:0] c, logic start);
      if (idling_on && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_char_code    <= c;
      req_string_start <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (sb.note_request(c, start)) active_items++;
   endtask

   task automatic send_text(string s, logic flag_first);
      for (int i = 0; i < s.len(); i++) send_char(s[i], flag_first && (i == 0));
   endtask

   task automatic send_random_string();
      logic [CHAR_W-1:0] text[$];
      string             hex_chars;
      int                n;
      bit                long_run;
      hex_chars = "0123456789abcdefABCDEF";
      // plain noise, with string starts scattered through it
      if ($urandom_range(0, 99) < 15) begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++)
            send_char(CHAR_W'($urandom_range(0, 255)),
                      (i == 0) || ($urandom_range(0, 7) == 0));
         return;
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3))
            text.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      case ($urandom_range(0, 2))
         1: text.push_back(CHAR_PLUS);
         2: text.push_back(CHAR_MINUS);
         default: ;
      endcase
      if (text.size() != 0 && $urandom_range(0, 4) == 0)
         text.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      long_run = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 3))
         2: begin
            text.push_back(CHAR_ZERO);
            text.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
            n = long_run ? $urandom_range(15, 20) : $urandom_range(0, 5);
            repeat (n) text.push_back(hex_chars[$urandom_range(0, 21)]);
         end
         3: begin
            text.push_back(CHAR_ZERO);
            n = long_run ? $urandom_range(20, 24) : $urandom_range(0, 5);
            repeat (n) text.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(0, 7)));
         end
         default: begin
            n = long_run ? $urandom_range(17, 24) : $urandom_range(1, 6);
            text.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(1, 9)));
            repeat (n - 1) text.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(0, 9)));
         end
      endcase
      // no terminator leaves the parse to be dropped by the next string
      n = $urandom_range(0, 9);
      if (n < 6)      text.push_back(CHAR_NUL);
      else if (n < 8) text.push_back(CHAR_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) text.push_back(CHAR_W'($urandom_range(0, 255)));
      foreach (text[i]) send_char(text[i], i == 0);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_text("0", 1'b1);
      send_char(CHAR_NUL, 1'b0);
      // bare hex prefix, ended by the top character code
      send_text("0x", 1'b1);
      send_char(8'hFF, 1'b0);
      send_text("09", 1'b1);
      send_text("-0XaF!", 1'b1);
      send_text("\t+017 ", 1'b1);
      // ignored once the value is out
      send_text("5", 1'b0);
      // abandoned parse, then a sign with no digits
      send_text("12", 1'b1);
      send_text("-", 1'b1);
      send_char(CHAR_NUL, 1'b0);
      send_char(CHAR_NUL, 1'b1);

      while (active_items < ITEM_COUNT) begin
         if (active_items >= QUIET_FROM) idling_on = 1'b0;
         if ($urandom_range(0, 15) == 0)
            req_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
         send_random_string();
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
